>>> design/kpf_pkg.sv
// ----------------------------------------------------------------------------
// Keyboard packet filter package
// Shared types and constants for the keyboard packet filter and key queue.
// ----------------------------------------------------------------------------
`default_nettype none

package kpf_pkg;

    localparam int KEY_DEPTH     = 256;
    localparam int BYTE_W        = 8;
    localparam int BREAK_BIT     = 7;
    localparam int CMDQ_DEPTH    = 2;
    localparam logic [BYTE_W-1:0] THRESH_RESET = 8'd248;
    localparam logic [BYTE_W-1:0] ZERO_BYTE    = 8'd0;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DX   = 2'd1,
        PH_DY   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        OP_NOP  = 2'd0,
        OP_PUSH = 2'd1,
        OP_READ = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
    } cmd_t;

endpackage

`default_nettype wire

>>> design/kpf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/kpf_front.sv
// ----------------------------------------------------------------------------
// Keyboard packet filter front end
// Tracks the mouse packet phase and turns each transfer into a queue command.
// ----------------------------------------------------------------------------
`default_nettype none

module kpf_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [kpf_pkg::BYTE_W-1:0] cfg_wdata,
    input  wire logic                       accept,
    input  wire logic                       action,
    input  wire logic [kpf_pkg::BYTE_W-1:0] rx_byte,
    output kpf_pkg::cmd_t                   cmd
);

    kpf_pkg::phase_t              phase_reg, phase_next;
    logic [kpf_pkg::BYTE_W-1:0]   thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= kpf_pkg::PH_IDLE;
            thresh_reg <= kpf_pkg::THRESH_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            if (cfg_we)
            begin
                thresh_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (accept && !action && rx_byte != kpf_pkg::ZERO_BYTE)
        begin
            unique case (phase_reg)
                kpf_pkg::PH_IDLE:
                begin
                    if (rx_byte >= thresh_reg)
                    begin
                        phase_next = kpf_pkg::PH_DX;
                    end
                end
                kpf_pkg::PH_DX: phase_next = kpf_pkg::PH_DY;
                default:        phase_next = kpf_pkg::PH_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd.op   = kpf_pkg::OP_NOP;
        cmd.data = rx_byte;
        if (action)
        begin
            cmd.op = kpf_pkg::OP_READ;
        end
        else if (phase_reg == kpf_pkg::PH_IDLE && rx_byte != kpf_pkg::ZERO_BYTE
                 && rx_byte < thresh_reg && !rx_byte[kpf_pkg::BREAK_BIT])
        begin
            cmd.op = kpf_pkg::OP_PUSH;
        end
    end

endmodule

`default_nettype wire

>>> design/kpf_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short queue that decouples the front end from the key buffer back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kpf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire kpf_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               not_empty,
    output kpf_pkg::cmd_t      head_cmd
);

    localparam int IW = $clog2(kpf_pkg::CMDQ_DEPTH);
    localparam int CW = $clog2(kpf_pkg::CMDQ_DEPTH + 1);

    kpf_pkg::cmd_t  entry_reg [kpf_pkg::CMDQ_DEPTH];
    logic [IW-1:0]  wr_idx_reg, wr_idx_next;
    logic [IW-1:0]  rd_idx_reg, rd_idx_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full      = (count_reg == CW'(kpf_pkg::CMDQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = entry_reg[rd_idx_reg];

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_idx_next = (wr_idx_reg == IW'(kpf_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_idx_next = (rd_idx_reg == IW'(kpf_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_idx_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> design/kpf_exec.sv
// ----------------------------------------------------------------------------
// Key buffer back end
// Executes queued commands against the key ring buffer and forms results.
// ----------------------------------------------------------------------------
`default_nettype none

module kpf_exec #(
    parameter int DEPTH = kpf_pkg::KEY_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_avail,
    input  wire kpf_pkg::cmd_t              cmd,
    output logic                            cmd_pop,
    output logic                            done,
    output logic                            key_waiting,
    output logic [kpf_pkg::BYTE_W-1:0]      key_code,
    output logic                            key_valid,
    output logic                            read_empty,
    output logic                            overflow
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          done_reg, waiting_reg, valid_reg, empty_reg, ovf_reg;
    logic          valid_next, empty_next, ovf_next;
    logic          mem_we, mem_re;
    logic [kpf_pkg::BYTE_W-1:0] mem_rdata;

    assign cmd_pop = cmd_avail;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        valid_next  = 1'b0;
        empty_next  = 1'b0;
        ovf_next    = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        if (cmd_avail)
        begin
            unique case (cmd.op)
                kpf_pkg::OP_PUSH:
                begin
                    if (count_reg == CW'(DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        mem_we      = 1'b1;
                        wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
                        count_next  = count_reg + 1'b1;
                    end
                end
                kpf_pkg::OP_READ:
                begin
                    if (count_reg == '0)
                    begin
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        mem_re      = 1'b1;
                        valid_next  = 1'b1;
                        rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                        count_next  = count_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            waiting_reg <= 1'b0;
            valid_reg   <= 1'b0;
            empty_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            count_reg   <= count_next;
            done_reg    <= cmd_avail;
            waiting_reg <= (count_next != '0);
            valid_reg   <= valid_next;
            empty_reg   <= empty_next;
            ovf_reg     <= ovf_next;
        end
    end

    kpf_ram #(
        .WIDTH (kpf_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_ptr_reg),
        .wdata (cmd.data),
        .re    (mem_re),
        .raddr (rd_ptr_reg),
        .rdata (mem_rdata)
    );

    assign done        = done_reg;
    assign key_waiting = waiting_reg;
    assign key_valid   = valid_reg;
    assign read_empty  = empty_reg;
    assign overflow    = ovf_reg;
    assign key_code    = valid_reg ? mem_rdata : kpf_pkg::ZERO_BYTE;

endmodule

`default_nettype wire

>>> design/keyboard_packet_filter_fifo.sv
// ----------------------------------------------------------------------------
// Keyboard packet filter with key FIFO
// Filters controller bytes, skips mouse packets and buffers make codes.
// ----------------------------------------------------------------------------
// An accepted transfer is queued, then its registered result strobes on done.
// Throughput: one transfer per cycle unless busy; the back end retires one
// queued command per cycle with a single key RAM access.
// Reset clears the packet phase, pointers and fill count; the threshold
// returns to 248. Results cannot be stalled by the receiver.
`default_nettype none

module keyboard_packet_filter_fifo #(
    parameter int DEPTH = kpf_pkg::KEY_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [kpf_pkg::BYTE_W-1:0] cfg_wdata,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       action,
    input  wire logic [kpf_pkg::BYTE_W-1:0] rx_byte,
    output logic                            done,
    output logic                            key_waiting,
    output logic [kpf_pkg::BYTE_W-1:0]      key_code,
    output logic                            key_valid,
    output logic                            read_empty,
    output logic                            overflow
);

    kpf_pkg::cmd_t front_cmd, head_cmd;
    logic          accept, q_full, q_avail, q_pop;

    assign busy   = q_full;
    assign accept = start && !q_full;

    kpf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .action    (action),
        .rx_byte   (rx_byte),
        .cmd       (front_cmd)
    );

    kpf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_cmd  (front_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_avail),
        .head_cmd  (head_cmd)
    );

    kpf_exec #(
        .DEPTH (DEPTH)
    ) u_exec (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_avail   (q_avail),
        .cmd         (head_cmd),
        .cmd_pop     (q_pop),
        .done        (done),
        .key_waiting (key_waiting),
        .key_code    (key_code),
        .key_valid   (key_valid),
        .read_empty  (read_empty),
        .overflow    (overflow)
    );

endmodule

`default_nettype wire

>>> design/kpf_checker.sv
// ----------------------------------------------------------------------------
// Keyboard packet filter checker
// Port-level checks on result timing and flag consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module kpf_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       done,
    input wire logic                       key_waiting,
    input wire logic [kpf_pkg::BYTE_W-1:0] key_code,
    input wire logic                       key_valid,
    input wire logic                       read_empty,
    input wire logic                       overflow
);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result did not follow a transfer after two cycles");

    a_flags_need_done: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!key_valid && !read_empty && !overflow))
        else $error("result flags set without a strobe");

    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        read_empty |-> (!key_waiting && !key_valid))
        else $error("empty read reported a waiting or popped key");

    a_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid |-> (key_code != kpf_pkg::ZERO_BYTE && !key_code[kpf_pkg::BREAK_BIT]))
        else $error("popped key is not a make code");

endmodule

bind keyboard_packet_filter_fifo kpf_checker u_kpf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .key_waiting (key_waiting),
    .key_code    (key_code),
    .key_valid   (key_valid),
    .read_empty  (read_empty),
    .overflow    (overflow)
);

`default_nettype wire
